// ===== rtl/xcfp_pkg.sv =====
// shared types and constants for the command frame parser
package xcfp_pkg;

	localparam int unsigned MAX_LEN = 16;
	localparam int unsigned NUM_KEPT = 4;

	localparam logic [7:0] TUNER_BYTE = 8'h50;
	localparam logic [7:0] MIN_LEN_FLOOR = 8'd2;

	localparam logic [2:0] EV_NONE = 3'd0;
	localparam logic [2:0] EV_OK = 3'd1;
	localparam logic [2:0] EV_LEN_ERR = 3'd2;
	localparam logic [2:0] EV_SUM_ERR = 3'd3;
	localparam logic [2:0] EV_UNKNOWN = 3'd4;
	localparam logic [2:0] EV_TIMEOUT = 3'd5;
	localparam logic [2:0] EV_TUNER = 3'd6;

	localparam logic [7:0] TYPE_JOYSTICK = 8'd1;
	localparam logic [7:0] TYPE_MODE = 8'd2;
	localparam logic [7:0] TYPE_HEIGHT = 8'd3;
	localparam logic [7:0] TYPE_EMERGENCY = 8'd4;
	localparam logic [7:0] TYPE_HEARTBEAT = 8'd5;

	localparam logic [7:0] MODE_A = 8'd0;
	localparam logic [7:0] MODE_B = 8'd2;
	localparam logic [7:0] MODE_C = 8'd3;
	localparam logic [7:0] MODE_D = 8'd6;

	localparam logic [1:0] STEP_UP = 2'b01;
	localparam logic [1:0] STEP_DOWN = 2'b11;
	localparam logic [1:0] STEP_NONE = 2'b00;

	localparam logic [2:0] REG_HEADER = 3'd0;
	localparam logic [2:0] REG_MIN_LEN = 3'd1;
	localparam logic [2:0] REG_TIMEOUT = 3'd2;
	localparam logic [2:0] REG_UP = 3'd3;
	localparam logic [2:0] REG_DOWN = 3'd4;
	localparam logic [2:0] REG_STOP = 3'd5;
	localparam logic [2:0] REG_RESUME = 3'd6;

	localparam logic [7:0] RST_HEADER = 8'h5A;
	localparam logic [7:0] RST_MIN_LEN = 8'd2;
	localparam logic [7:0] RST_TIMEOUT = 8'd13;
	localparam logic [7:0] RST_UP = 8'd1;
	localparam logic [7:0] RST_DOWN = 8'd2;
	localparam logic [7:0] RST_STOP = 8'd1;
	localparam logic [7:0] RST_RESUME = 8'd0;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_LENGTH,
		PH_TYPE,
		PH_DATA,
		PH_CHECK
	} phase_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_TUNER,
		OP_LEN_ERR,
		OP_GOOD,
		OP_BAD_SUM,
		OP_TICK
	} op_kind_t;

	typedef struct packed {
		op_kind_t    kind;
		logic [7:0]  frame_type;
		logic [31:0] data;
	} op_t;

	typedef struct packed {
		logic [7:0] header_byte;
		logic [7:0] min_len_field;
		logic [7:0] timeout_ticks;
		logic [7:0] height_up_code;
		logic [7:0] height_down_code;
		logic [7:0] stop_code;
		logic [7:0] resume_code;
	} cfg_t;

endpackage

// ===== rtl/xcfp_if.sv =====
// request and result channel interfaces
interface xcfp_in_if;
	logic       valid;
	logic       ready;
	logic       cmd;
	logic [7:0] data_byte;

	modport source (output valid, output cmd, output data_byte, input ready);
	modport sink (input valid, input cmd, input data_byte, output ready);
endinterface

interface xcfp_out_if;
	logic               valid;
	logic               ready;
	logic        [2:0]  event_res;
	logic        [7:0]  frame_kind;
	logic signed [15:0] axis_forward;
	logic signed [15:0] axis_turn;
	logic        [2:0]  steer_mode;
	logic signed [1:0]  height_step;
	logic               emergency_flag;
	logic               stop_latched;
	logic               zero_drive;
	logic               link_active;
	logic        [15:0] good_frames;
	logic        [15:0] bad_frames;

	modport source (
		output valid, output event_res, output frame_kind, output axis_forward,
		output axis_turn, output steer_mode, output height_step, output emergency_flag,
		output stop_latched, output zero_drive, output link_active, output good_frames,
		output bad_frames, input ready
	);
	modport sink (
		input valid, input event_res, input frame_kind, input axis_forward,
		input axis_turn, input steer_mode, input height_step, input emergency_flag,
		input stop_latched, input zero_drive, input link_active, input good_frames,
		input bad_frames, output ready
	);
endinterface

// ===== rtl/xor_checked_command_frame_parser_core.sv =====
// top level: configuration registers, parser, request queue and executor
// Takes one request per cycle while the request queue is not full (a received byte or a
// tick) and returns one result per request. Each accepted request passes through the
// request queue and the registered result stage before its result is presented. The parser
// classifies the byte combinationally and writes it into the two-entry request queue at the
// accepting edge. The executor pops it into the registered result stage, from which the
// result is taken. The parser and the executor stall independently, so a waiting result
// does not block new requests until the queue and result register are full. Configuration
// writes take effect at once; the user makes them while the block is idle (not enforced).
module xor_checked_command_frame_parser_core (
	input  logic       clk,
	input  logic       arst_n,
	xcfp_in_if.sink    in_ch,
	xcfp_out_if.source out_ch,
	input  logic       cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_data
);
	import xcfp_pkg::*;

	cfg_t cfg_q;
	op_t  push_op;
	op_t  pop_op;
	logic push;
	logic pop;
	logic full;
	logic empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_byte <= RST_HEADER;
			cfg_q.min_len_field <= RST_MIN_LEN;
			cfg_q.timeout_ticks <= RST_TIMEOUT;
			cfg_q.height_up_code <= RST_UP;
			cfg_q.height_down_code <= RST_DOWN;
			cfg_q.stop_code <= RST_STOP;
			cfg_q.resume_code <= RST_RESUME;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HEADER: cfg_q.header_byte <= cfg_data;
				REG_MIN_LEN: cfg_q.min_len_field <= cfg_data;
				REG_TIMEOUT: cfg_q.timeout_ticks <= cfg_data;
				REG_UP: cfg_q.height_up_code <= cfg_data;
				REG_DOWN: cfg_q.height_down_code <= cfg_data;
				REG_STOP: cfg_q.stop_code <= cfg_data;
				REG_RESUME: cfg_q.resume_code <= cfg_data;
				default: ;
			endcase
		end
	end

	xcfp_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.cfg    (cfg_q),
		.q_full (full),
		.q_push (push),
		.q_op   (push_op)
	);

	xcfp_op_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.pop     (pop),
		.pop_op  (pop_op),
		.full    (full),
		.empty   (empty)
	);

	xcfp_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_empty (empty),
		.q_op    (pop_op),
		.q_pop   (pop),
		.out_ch  (out_ch)
	);

endmodule

// ===== rtl/xcfp_front.sv =====
// byte parser: frames bytes, checks the sum and classifies each request
module xcfp_front (
	input  logic          clk,
	input  logic          arst_n,
	xcfp_in_if.sink       in_ch,
	input  xcfp_pkg::cfg_t cfg,
	input  logic          q_full,
	output logic          q_push,
	output xcfp_pkg::op_t q_op
);
	import xcfp_pkg::*;

	phase_t      phase_q, phase_d;
	logic [7:0]  len_q, len_d;
	logic [7:0]  kind_q, kind_d;
	logic [7:0]  widx_q, widx_d;
	logic [7:0]  xor_q, xor_d;
	logic [7:0]  buf_q [NUM_KEPT];
	logic        buf_we;
	logic [7:0]  lo_len;
	logic [8:0]  widx_sum;
	logic        accept;
	logic [7:0]  b;

	assign in_ch.ready = !q_full;
	assign accept = in_ch.valid && !q_full;
	assign q_push = accept;
	assign b = in_ch.data_byte;
	assign lo_len = (cfg.min_len_field < MIN_LEN_FLOOR) ? MIN_LEN_FLOOR : cfg.min_len_field;
	assign widx_sum = {1'b0, widx_q} + 9'd3;

	always_comb begin
		phase_d = phase_q;
		len_d = len_q;
		kind_d = kind_q;
		widx_d = widx_q;
		xor_d = xor_q;
		buf_we = 1'b0;
		q_op.kind = OP_NONE;
		q_op.frame_type = kind_q;
		q_op.data = {buf_q[3], buf_q[2], buf_q[1], buf_q[0]};
		if (in_ch.cmd) begin
			q_op.kind = OP_TICK;
		end else begin
			case (phase_q)
				PH_HEADER: begin
					if (b == cfg.header_byte) begin
						xor_d = 8'd0;
						phase_d = PH_LENGTH;
					end else if (b == TUNER_BYTE) begin
						q_op.kind = OP_TUNER;
					end
				end
				PH_LENGTH: begin
					len_d = b;
					xor_d = b;
					if (b < lo_len || b > 8'(MAX_LEN)) begin
						q_op.kind = OP_LEN_ERR;
						phase_d = PH_HEADER;
						len_d = 8'd0;
						kind_d = 8'd0;
						widx_d = 8'd0;
						xor_d = 8'd0;
					end else begin
						phase_d = PH_TYPE;
					end
				end
				PH_TYPE: begin
					kind_d = b;
					xor_d = xor_q ^ b;
					if (len_q <= 8'd2) begin
						phase_d = PH_CHECK;
					end else begin
						widx_d = 8'd0;
						phase_d = PH_DATA;
					end
				end
				PH_DATA: begin
					buf_we = (widx_q < 8'(NUM_KEPT));
					widx_d = widx_q + 8'd1;
					xor_d = xor_q ^ b;
					if (widx_sum >= {1'b0, len_q}) begin
						phase_d = PH_CHECK;
					end
				end
				PH_CHECK: begin
					q_op.kind = (b == xor_q) ? OP_GOOD : OP_BAD_SUM;
					phase_d = PH_HEADER;
					len_d = 8'd0;
					kind_d = 8'd0;
					widx_d = 8'd0;
					xor_d = 8'd0;
				end
				default: begin
					phase_d = PH_HEADER;
					len_d = 8'd0;
					kind_d = 8'd0;
					widx_d = 8'd0;
					xor_d = 8'd0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			len_q <= 8'd0;
			kind_q <= 8'd0;
			widx_q <= 8'd0;
			xor_q <= 8'd0;
			for (int i = 0; i < NUM_KEPT; i++) begin
				buf_q[i] <= 8'd0;
			end
		end else if (accept) begin
			phase_q <= phase_d;
			len_q <= len_d;
			kind_q <= kind_d;
			widx_q <= widx_d;
			xor_q <= xor_d;
			if (buf_we) begin
				buf_q[widx_q[1:0]] <= b;
			end
		end
	end

endmodule

// ===== rtl/xcfp_op_fifo.sv =====
// two-entry queue of classified requests between parser and executor
module xcfp_op_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  xcfp_pkg::op_t push_op,
	input  logic          pop,
	output xcfp_pkg::op_t pop_op,
	output logic          full,
	output logic          empty
);
	import xcfp_pkg::*;

	op_t        mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);
	assign pop_op = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10: count_q <= count_q + 2'd1;
				2'b01: count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/xcfp_back.sv =====
// executor: link timeout, counters, command decode and result register
module xcfp_back (
	input  logic           clk,
	input  logic           arst_n,
	input  xcfp_pkg::cfg_t cfg,
	input  logic           q_empty,
	input  xcfp_pkg::op_t  q_op,
	output logic           q_pop,
	xcfp_out_if.source     out_ch
);
	import xcfp_pkg::*;

	logic [7:0]  idle_q, idle_d, idle_inc;
	logic        active_q, active_d;
	logic        emerg_q, emerg_d;
	logic        stop_q, stop_d;
	logic [2:0]  mode_q, mode_d;
	logic [31:0] axes_q, axes_d;
	logic [15:0] ok_q, ok_d;
	logic [15:0] err_q, err_d;
	logic [2:0]  ev;
	logic [7:0]  kind;
	logic [1:0]  step;
	logic        zero;
	logic [7:0]  d0;
	logic        valid_q;

	assign q_pop = !q_empty && (!valid_q || out_ch.ready);
	assign out_ch.valid = valid_q;
	assign d0 = q_op.data[7:0];
	assign idle_inc = idle_q + 8'd1;

	always_comb begin
		idle_d = idle_q;
		active_d = active_q;
		emerg_d = emerg_q;
		stop_d = stop_q;
		mode_d = mode_q;
		axes_d = axes_q;
		ok_d = ok_q;
		err_d = err_q;
		ev = EV_NONE;
		kind = 8'd0;
		step = STEP_NONE;
		zero = 1'b0;
		case (q_op.kind)
			OP_TICK: begin
				if (active_q) begin
					idle_d = idle_inc;
					if (idle_inc >= cfg.timeout_ticks) begin
						active_d = 1'b0;
						emerg_d = 1'b0;
						idle_d = 8'd0;
						zero = 1'b1;
						ev = EV_TIMEOUT;
					end
				end
			end
			OP_TUNER: ev = EV_TUNER;
			OP_LEN_ERR: begin
				err_d = err_q + 16'd1;
				ev = EV_LEN_ERR;
			end
			OP_BAD_SUM: begin
				err_d = err_q + 16'd1;
				ev = EV_SUM_ERR;
			end
			OP_GOOD: begin
				idle_d = 8'd0;
				active_d = 1'b1;
				ok_d = ok_q + 16'd1;
				kind = q_op.frame_type;
				ev = EV_OK;
				case (q_op.frame_type)
					TYPE_JOYSTICK: axes_d = q_op.data;
					TYPE_MODE: begin
						if (d0 == MODE_A || d0 == MODE_B || d0 == MODE_C || d0 == MODE_D) begin
							mode_d = d0[2:0];
						end
					end
					TYPE_HEIGHT: begin
						if (d0 == cfg.height_up_code) begin
							step = STEP_UP;
						end else if (d0 == cfg.height_down_code) begin
							step = STEP_DOWN;
						end
					end
					TYPE_EMERGENCY: begin
						if (d0 == cfg.stop_code) begin
							emerg_d = 1'b1;
							stop_d = 1'b1;
							zero = 1'b1;
						end else if (d0 == cfg.resume_code) begin
							emerg_d = 1'b0;
							stop_d = 1'b0;
						end
					end
					TYPE_HEARTBEAT: ;
					default: begin
						err_d = err_q + 16'd1;
						ev = EV_UNKNOWN;
					end
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_q <= 8'd0;
			active_q <= 1'b0;
			emerg_q <= 1'b0;
			stop_q <= 1'b0;
			mode_q <= 3'd0;
			axes_q <= 32'd0;
			ok_q <= 16'd0;
			err_q <= 16'd0;
			valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				idle_q <= idle_d;
				active_q <= active_d;
				emerg_q <= emerg_d;
				stop_q <= stop_d;
				mode_q <= mode_d;
				axes_q <= axes_d;
				ok_q <= ok_d;
				err_q <= err_d;
				valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			out_ch.event_res <= ev;
			out_ch.frame_kind <= kind;
			out_ch.axis_forward <= axes_d[15:0];
			out_ch.axis_turn <= axes_d[31:16];
			out_ch.steer_mode <= mode_d;
			out_ch.height_step <= step;
			out_ch.emergency_flag <= emerg_d;
			out_ch.stop_latched <= stop_d;
			out_ch.zero_drive <= zero;
			out_ch.link_active <= active_d;
			out_ch.good_frames <= ok_d;
			out_ch.bad_frames <= err_d;
		end
	end

endmodule

// ===== sim/xor_checked_command_frame_parser_core_tb.sv =====
// self-checking testbench for the command frame parser core with random handshake pressure
`timescale 1ns / 100ps

module xor_checked_command_frame_parser_core_tb;
	import xcfp_pkg::*;

	localparam int unsigned HANG_LIMIT = 2000;
	localparam int unsigned N_ROWS = 27;
	localparam int unsigned PAYLOAD_DEPTH = MAX_LEN + 4;

	typedef struct packed {
		logic [2:0]  ev;
		logic [7:0]  kind;
		logic [15:0] fwd;
		logic [15:0] turn;
		logic [2:0]  mode;
		logic [1:0]  hstep;
		logic        emg;
		logic        stop;
		logic        zero;
		logic        link;
		logic [15:0] good;
		logic [15:0] bad;
	} report_t;

	typedef struct packed {
		logic       cmd;
		logic [7:0] data;
		logic       pinned;
		logic [2:0] ev;
	} row_t;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_RANDOM,
		RX_PERIODIC,
		RX_SPARSE
	} rx_pattern_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_we;
	logic [2:0] cfg_index;
	logic [7:0] cfg_data;

	xcfp_in_if  in_ch();
	xcfp_out_if out_ch();

	xor_checked_command_frame_parser_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.out_ch   (out_ch),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	cfg_t        cfg_m = '{RST_HEADER, RST_MIN_LEN, RST_TIMEOUT, RST_UP, RST_DOWN,
		RST_STOP, RST_RESUME};
	phase_t      ph = PH_HEADER;
	logic [7:0]  len_q = '0;
	logic [7:0]  kind_q = '0;
	logic [7:0]  idx_q = '0;
	logic [7:0]  xor_q = '0;
	logic [7:0]  idle_q = '0;
	logic [7:0]  payload [PAYLOAD_DEPTH] = '{default: 8'h00};
	logic        act_q = 1'b0;
	logic        emg_q = 1'b0;
	logic        stop_q = 1'b0;
	logic [2:0]  mode_q = '0;
	logic [31:0] axes_q = '0;
	logic [15:0] good_q = '0;
	logic [15:0] bad_q = '0;

	report_t     pending_reports [$];
	int unsigned mismatches = 0;
	int unsigned hang_count = 0;
	int unsigned sent_count = 0;
	int unsigned burst_left = 0;
	logic        pin_on = 1'b0;
	logic [2:0]  pin_ev = EV_NONE;

	rx_pattern_t rx_mode = RX_OPEN;
	int unsigned rx_left = 0;
	int unsigned rx_phase = 0;

	cfg_t settings [5];

	row_t script [N_ROWS] = '{
		'{1'b1, 8'h00, 1'b1, EV_NONE},
		'{1'b0, TUNER_BYTE, 1'b1, EV_TUNER},
		'{1'b0, RST_HEADER, 1'b0, EV_NONE},
		'{1'b0, 8'h01, 1'b1, EV_LEN_ERR},
		'{1'b0, RST_HEADER, 1'b0, EV_NONE},
		'{1'b0, 8'h11, 1'b1, EV_LEN_ERR},
		'{1'b0, RST_HEADER, 1'b0, EV_NONE},
		'{1'b0, 8'h06, 1'b0, EV_NONE},
		'{1'b0, TYPE_JOYSTICK, 1'b0, EV_NONE},
		'{1'b0, RST_HEADER, 1'b0, EV_NONE},
		'{1'b0, 8'h7F, 1'b0, EV_NONE},
		'{1'b0, 8'h00, 1'b0, EV_NONE},
		'{1'b0, 8'h80, 1'b0, EV_NONE},
		'{1'b0, 8'hA2, 1'b1, EV_OK},
		'{1'b0, RST_HEADER, 1'b0, EV_NONE},
		'{1'b0, 8'h03, 1'b0, EV_NONE},
		'{1'b0, TYPE_EMERGENCY, 1'b0, EV_NONE},
		'{1'b0, RST_STOP, 1'b0, EV_NONE},
		'{1'b0, 8'h06, 1'b1, EV_OK},
		'{1'b0, RST_HEADER, 1'b0, EV_NONE},
		'{1'b0, 8'h02, 1'b0, EV_NONE},
		'{1'b0, 8'hFF, 1'b0, EV_NONE},
		'{1'b0, 8'hFD, 1'b1, EV_UNKNOWN},
		'{1'b0, RST_HEADER, 1'b0, EV_NONE},
		'{1'b0, 8'h02, 1'b0, EV_NONE},
		'{1'b0, TYPE_HEARTBEAT, 1'b0, EV_NONE},
		'{1'b0, 8'h00, 1'b1, EV_SUM_ERR}
	};

	function automatic void clear_parser();
		ph = PH_HEADER;
		len_q = '0;
		kind_q = '0;
		idx_q = '0;
		xor_q = '0;
	endfunction

	function automatic report_t parse_request(input logic c, input logic [7:0] b);
		report_t    r;
		logic [7:0] lo;
		logic [7:0] m;
		r = '0;
		if (c) begin
			if (act_q) begin
				idle_q = idle_q + 8'd1;
				if (idle_q >= cfg_m.timeout_ticks) begin
					act_q = 1'b0;
					emg_q = 1'b0;
					idle_q = '0;
					r.zero = 1'b1;
					r.ev = EV_TIMEOUT;
				end
			end
		end else begin
			case (ph)
				PH_HEADER: begin
					if (b == cfg_m.header_byte) begin
						xor_q = '0;
						ph = PH_LENGTH;
					end else if (b == TUNER_BYTE) begin
						r.ev = EV_TUNER;
					end
				end
				PH_LENGTH: begin
					lo = (cfg_m.min_len_field < MIN_LEN_FLOOR) ? MIN_LEN_FLOOR
						: cfg_m.min_len_field;
					len_q = b;
					xor_q = b;
					if (b < lo || b > MAX_LEN) begin
						bad_q = bad_q + 16'd1;
						r.ev = EV_LEN_ERR;
						clear_parser();
					end else begin
						ph = PH_TYPE;
					end
				end
				PH_TYPE: begin
					kind_q = b;
					xor_q = xor_q ^ b;
					if (len_q <= 8'd2) begin
						ph = PH_CHECK;
					end else begin
						idx_q = '0;
						ph = PH_DATA;
					end
				end
				PH_DATA: begin
					if (idx_q < PAYLOAD_DEPTH)
						payload[idx_q] = b;
					idx_q = idx_q + 8'd1;
					xor_q = xor_q ^ b;
					if (32'(idx_q) + 2 >= 32'(len_q))
						ph = PH_CHECK;
				end
				PH_CHECK: begin
					if (b == xor_q) begin
						idle_q = '0;
						act_q = 1'b1;
						good_q = good_q + 16'd1;
						r.kind = kind_q;
						r.ev = EV_OK;
						case (kind_q)
							TYPE_JOYSTICK: axes_q = {payload[3], payload[2], payload[1], payload[0]};
							TYPE_MODE: begin
								m = payload[0];
								if (m == MODE_A || m == MODE_B || m == MODE_C || m == MODE_D)
									mode_q = m[2:0];
							end
							TYPE_HEIGHT: begin
								if (payload[0] == cfg_m.height_up_code)
									r.hstep = STEP_UP;
								else if (payload[0] == cfg_m.height_down_code)
									r.hstep = STEP_DOWN;
							end
							TYPE_EMERGENCY: begin
								if (payload[0] == cfg_m.stop_code) begin
									emg_q = 1'b1;
									stop_q = 1'b1;
									r.zero = 1'b1;
								end else if (payload[0] == cfg_m.resume_code) begin
									emg_q = 1'b0;
									stop_q = 1'b0;
								end
							end
							TYPE_HEARTBEAT: ;
							default: begin
								bad_q = bad_q + 16'd1;
								r.ev = EV_UNKNOWN;
							end
						endcase
					end else begin
						bad_q = bad_q + 16'd1;
						r.ev = EV_SUM_ERR;
					end
					clear_parser();
				end
				default: clear_parser();
			endcase
		end
		r.fwd = axes_q[15:0];
		r.turn = axes_q[31:16];
		r.mode = mode_q;
		r.emg = emg_q;
		r.stop = stop_q;
		r.link = act_q;
		r.good = good_q;
		r.bad = bad_q;
		return r;
	endfunction

	function automatic string show(input report_t r);
		return $sformatf({"ev=%0d kind=%02h fwd=%0d turn=%0d mode=%0d hstep=%0d emg=%b ",
			"stop=%b zero=%b link=%b good=%0d bad=%0d"}, r.ev, r.kind, $signed(r.fwd),
			$signed(r.turn), r.mode, $signed(r.hstep), r.emg, r.stop, r.zero, r.link,
			r.good, r.bad);
	endfunction

	// scoreboard and hang watchdog
	always @(posedge clk) begin
		report_t want;
		report_t got;
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				got.ev = out_ch.event_res;
				got.kind = out_ch.frame_kind;
				got.fwd = out_ch.axis_forward;
				got.turn = out_ch.axis_turn;
				got.mode = out_ch.steer_mode;
				got.hstep = out_ch.height_step;
				got.emg = out_ch.emergency_flag;
				got.stop = out_ch.stop_latched;
				got.zero = out_ch.zero_drive;
				got.link = out_ch.link_active;
				got.good = out_ch.good_frames;
				got.bad = out_ch.bad_frames;
				if (pending_reports.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result with no request pending: %s", show(got));
				end else begin
					want = pending_reports.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch\n  exp %s\n  got %s", show(want), show(got));
					end
				end
			end
			if (in_ch.valid && in_ch.ready) begin
				want = parse_request(in_ch.cmd, in_ch.data_byte);
				if (pin_on)
					want.ev = pin_ev;
				pending_reports.push_back(want);
			end
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				hang_count = 0;
			else
				hang_count++;
			if (hang_count >= HANG_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	// result-side backpressure
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_pattern_t'($urandom_range(0, 3));
			rx_left = $urandom_range(20, 200);
		end
		rx_left--;
		rx_phase++;
		case (rx_mode)
			RX_OPEN: out_ch.ready <= 1'b1;
			RX_RANDOM: out_ch.ready <= ($urandom_range(0, 9) > 2);
			RX_PERIODIC: out_ch.ready <= (rx_phase % 5 != 0);
			default: out_ch.ready <= (rx_phase % 8 < 2);
		endcase
	end

	task automatic send_req(input logic c, input logic [7:0] b);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 16);
			gap = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
			if (gap > 0) begin
				in_ch.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		in_ch.valid <= 1'b1;
		in_ch.cmd <= c;
		in_ch.data_byte <= b;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		@(negedge clk);
		burst_left--;
		sent_count++;
	endtask

	task automatic send_frame();
		int unsigned lo;
		int unsigned len;
		int unsigned sel;
		logic [7:0]  kind;
		logic [7:0]  cks;
		logic [7:0]  d;
		lo = (cfg_m.min_len_field < MIN_LEN_FLOOR) ? MIN_LEN_FLOOR : cfg_m.min_len_field;
		sel = $urandom_range(0, 99);
		if (lo > MAX_LEN || sel < 8)
			len = $urandom_range(0, 255);
		else if (sel < 15)
			len = MAX_LEN;
		else
			len = $urandom_range(lo, (lo + 4 > MAX_LEN) ? MAX_LEN : lo + 4);
		kind = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(1, 5))
			: 8'($urandom_range(0, 255));
		send_req(1'b0, cfg_m.header_byte);
		send_req(1'b0, 8'(len));
		if (len < lo || len > MAX_LEN)
			return;
		send_req(1'b0, kind);
		cks = 8'(len) ^ kind;
		for (int i = 0; i + 2 < len; i++) begin
			d = 8'($urandom_range(0, 255));
			if (i == 0) begin
				sel = $urandom_range(0, 3);
				case (kind)
					TYPE_MODE: begin
						case (sel)
							0: d = MODE_A;
							1: d = MODE_B;
							2: d = MODE_C;
							default: d = MODE_D;
						endcase
						if ($urandom_range(0, 3) == 0)
							d = 8'($urandom_range(0, 7));
					end
					TYPE_HEIGHT: begin
						if (sel == 0)
							d = cfg_m.height_up_code;
						else if (sel == 1)
							d = cfg_m.height_down_code;
					end
					TYPE_EMERGENCY: begin
						if (sel == 0)
							d = cfg_m.stop_code;
						else if (sel == 1)
							d = cfg_m.resume_code;
					end
					default: ;
				endcase
			end
			send_req(1'b0, d);
			cks = cks ^ d;
		end
		if ($urandom_range(0, 9) == 0)
			cks = cks ^ 8'($urandom_range(1, 255));
		send_req(1'b0, cks);
	endtask

	task automatic run_random(input int unsigned target);
		int unsigned start;
		int unsigned sel;
		int unsigned n;
		start = sent_count;
		while (sent_count - start < target) begin
			sel = $urandom_range(0, 99);
			if (sel < 60) begin
				send_frame();
			end else if (sel < 72) begin
				if ($urandom_range(0, 1) == 0)
					n = $urandom_range(1, 4);
				else
					n = $urandom_range(1, (cfg_m.timeout_ticks + 2 > 300) ? 300
						: cfg_m.timeout_ticks + 2);
				repeat (n) send_req(1'b1, 8'($urandom_range(0, 255)));
			end else if (sel < 82) begin
				send_req(1'b0, 8'($urandom_range(0, 255)));
			end else if (sel < 88) begin
				send_req(1'b0, TUNER_BYTE);
			end else begin
				// frame cut off part way
				send_req(1'b0, cfg_m.header_byte);
				repeat ($urandom_range(0, 3)) send_req(1'b0, 8'($urandom_range(0, 255)));
			end
		end
	endtask

	task automatic settle();
		in_ch.valid <= 1'b0;
		burst_left = 0;
		while (pending_reports.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic put_reg(input logic [2:0] idx, input logic [7:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
	endtask

	task automatic write_settings(input cfg_t s);
		put_reg(REG_HEADER, s.header_byte);
		put_reg(REG_MIN_LEN, s.min_len_field);
		put_reg(REG_TIMEOUT, s.timeout_ticks);
		put_reg(REG_UP, s.height_up_code);
		put_reg(REG_DOWN, s.height_down_code);
		put_reg(REG_STOP, s.stop_code);
		put_reg(REG_RESUME, s.resume_code);
		cfg_we <= 1'b0;
		cfg_m = s;
	endtask

	initial begin
		in_ch.valid = 1'b0;
		in_ch.cmd = 1'b0;
		in_ch.data_byte = '0;
		out_ch.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_HEADER;
		cfg_data = '0;
		arst_n = 1'b0;
		// header equal to the tuner byte, one-tick timeout
		settings[0] = '{TUNER_BYTE, MIN_LEN_FLOOR, 8'd1, 8'h00, 8'hFF, 8'hFF, 8'h00};
		// only full-size frames, longest timeout, equal code pairs
		settings[1] = '{8'h00, 8'd16, 8'hFF, 8'h07, 8'h07, 8'h03, 8'h03};
		// every length rejected
		settings[2] = '{8'hFF, 8'hFF, 8'd1, 8'hFF, 8'h00, 8'h00, 8'hFF};
		// timeout of zero expires on the first tick
		settings[3] = '{RST_HEADER, MIN_LEN_FLOOR, 8'd0, 8'h02, 8'h02, 8'h00, 8'h00};
		settings[4] = '{8'($urandom_range(0, 255)), 8'($urandom_range(2, 8)),
			8'($urandom_range(1, 20)), 8'($urandom_range(0, 7)), 8'($urandom_range(0, 7)),
			8'($urandom_range(0, 7)), 8'($urandom_range(0, 7))};
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < N_ROWS; i++) begin
			pin_on = script[i].pinned;
			pin_ev = script[i].ev;
			send_req(script[i].cmd, script[i].data);
		end
		pin_on = 1'b0;

		run_random(300);
		for (int p = 0; p < 5; p++) begin
			settle();
			write_settings(settings[p]);
			run_random(290);
		end
		settle();

		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/xcfp_pkg.sv
rtl/xcfp_if.sv
rtl/xcfp_front.sv
rtl/xcfp_op_fifo.sv
rtl/xcfp_back.sv
rtl/xor_checked_command_frame_parser_core.sv
sim/xor_checked_command_frame_parser_core_tb.sv
